/* hw/rtl/pld3_pkg.sv */
// Package for the point-to-line distance unit.
// Holds shared widths and constants; no dependencies.
`default_nettype none
package pld3_pkg;
  localparam int DIST_BITS = 25;
  localparam int LIM_BITS  = 8;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
endpackage
`default_nettype wire

/* hw/rtl/pld3_div_cell.sv */
// One restoring-division cell: produces one quotient bit per clock while enabled.
// Depends on pld3_pkg.
`default_nettype none
module pld3_div_cell #(
  parameter int NB = 8,
  parameter int DB = 8,
  parameter int QB = 8,
  parameter int BIT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_in,
  input  wire logic [NB-1:0] num_in,
  input  wire logic [DB-1:0] den_in,
  input  wire logic [NB:0]   rem_in,
  input  wire logic [QB-1:0] q_in,
  input  wire logic [DB:0]   aux_in,
  output logic               vld_out,
  output logic [NB-1:0]      num_out,
  output logic [DB-1:0]      den_out,
  output logic [NB:0]        rem_out,
  output logic [QB-1:0]      q_out,
  output logic [DB:0]        aux_out
);
  import pld3_pkg::*;
  logic [NB+1:0] shl;
  logic          ge;
  logic [NB:0]   rem_nxt;
  logic [QB-1:0] q_nxt;

  // Shift in the next numerator bit and try the subtraction.
  always_comb begin
    shl     = {rem_in, num_in[BIT]};
    ge      = shl >= (NB+2)'(den_in);
    rem_nxt = ge ? (NB+1)'(shl - (NB+2)'(den_in)) : shl[NB:0];
    q_nxt   = q_in;
    if (BIT < QB) q_nxt[BIT % QB] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= num_in;
      den_out <= den_in;
      rem_out <= rem_nxt;
      q_out   <= q_nxt;
      aux_out <= aux_in;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/pld3_sqrt_cell.sv */
// One square-root cell: settles one root bit per clock while enabled.
// Depends on pld3_pkg.
`default_nettype none
module pld3_sqrt_cell #(
  parameter int VB = 8,
  parameter int RB = 4,
  parameter int BIT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_in,
  input  wire logic [VB-1:0] v_in,
  input  wire logic [RB-1:0] r_in,
  input  wire logic [RB+1:0] rem_in,
  input  wire logic          flag_in,
  output logic               vld_out,
  output logic [VB-1:0]      v_out,
  output logic [RB-1:0]      r_out,
  output logic [RB+1:0]      rem_out,
  output logic               flag_out
);
  import pld3_pkg::*;
  logic [2*RB-1:0] vx;
  logic [RB+3:0]   acc;
  logic [RB+3:0]   trial;
  logic            ge;
  logic [RB+1:0]   rem_nxt;
  logic [RB-1:0]   r_nxt;

  // Bring down the next two value bits and try to subtract 4*root+1.
  always_comb begin
    vx      = (2*RB)'(v_in);
    acc     = {rem_in, vx[2*BIT+1 -: 2]};
    trial   = (RB+4)'({r_in, 2'b01});
    ge      = acc >= trial;
    rem_nxt = ge ? (RB+2)'(acc - trial) : acc[RB+1:0];
    r_nxt   = {r_in[RB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out    <= v_in;
      r_out    <= r_nxt;
      rem_out  <= rem_nxt;
      flag_out <= flag_in;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/point_line_distance_3d_unit.sv */
// Top level of the point-to-line distance unit: front-end arithmetic,
// a divider cell chain and a square-root cell chain. Depends on pld3_pkg and the cells.
//
//  channel | direction | beat contents
//  in_     | in        | points A, B, P (nine signed coordinates)
//  out_    | out       | distance, degenerate flag
//  cfg_    | in        | short_line_limit
//
// One beat per clock sustained while results are taken; the pipeline is 7 front stages,
// (4*COORD_BITS+8) divider cells, (2*COORD_BITS+4) root cells and the output register.
// The whole chain advances together and halts when the output register is full
// and not taken. Reset clears valid bits and sets the limit to one.
`default_nettype none
module point_line_distance_3d_unit #(
  parameter int COORD_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_a_z,
  input  wire logic signed [COORD_BITS-1:0] in_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_b_y,
  input  wire logic signed [COORD_BITS-1:0] in_b_z,
  input  wire logic signed [COORD_BITS-1:0] in_p_x,
  input  wire logic signed [COORD_BITS-1:0] in_p_y,
  input  wire logic signed [COORD_BITS-1:0] in_p_z,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [24:0] out_distance,
  output logic      out_degenerate,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [7:0] cfg_short_line_limit
);
  import pld3_pkg::*;
  localparam int DB = COORD_BITS + 1;
  localparam int SB = 2*DB + 2;
  localparam int CB = 2*DB + 1;
  localparam int HB = (CB + 1) / 2;
  localparam int NB = 2*CB + 2;
  localparam int LB = SB;
  localparam int RB = (NB + 1) / 2;

  logic          en;
  logic [7:0]    lim_r;

  // Output register; the chain moves when it is empty or being drained.
  logic          ov_r;
  logic [24:0]   od_r;
  logic          odeg_r;
  assign en        = !ov_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= 8'd1;
    end else if (cfg_valid) begin
      lim_r <= cfg_short_line_limit;
    end
  end

  // Stage 1: differences.
  logic                 v1_r;
  logic signed [DB-1:0] d1_r [3], d2_r [3], l_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= DB'(in_p_x) - DB'(in_a_x);
      d1_r[1] <= DB'(in_p_y) - DB'(in_a_y);
      d1_r[2] <= DB'(in_p_z) - DB'(in_a_z);
      d2_r[0] <= DB'(in_p_x) - DB'(in_b_x);
      d2_r[1] <= DB'(in_p_y) - DB'(in_b_y);
      d2_r[2] <= DB'(in_p_z) - DB'(in_b_z);
      l_r[0]  <= DB'(in_a_x) - DB'(in_b_x);
      l_r[1]  <= DB'(in_a_y) - DB'(in_b_y);
      l_r[2]  <= DB'(in_a_z) - DB'(in_b_z);
    end
  end

  // Stage 2: products.
  logic                   v2_r;
  logic signed [2*DB-1:0] pa_r [3], pb_r [3], q1_r [3], ql_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q1_r[i] <= d1_r[i] * d1_r[i];
        ql_r[i] <= l_r[i] * l_r[i];
      end
      pa_r[0] <= d1_r[1] * d2_r[2];  pb_r[0] <= d1_r[2] * d2_r[1];
      pa_r[1] <= d1_r[2] * d2_r[0];  pb_r[1] <= d1_r[0] * d2_r[2];
      pa_r[2] <= d1_r[0] * d2_r[1];  pb_r[2] <= d1_r[1] * d2_r[0];
    end
  end

  // Stage 3: cross components and squared lengths.
  logic                 v3_r;
  logic signed [CB-1:0] c_r [3];
  logic [SB-1:0]        len1_r, line_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c_r[i] <= CB'(pa_r[i]) - CB'(pb_r[i]);
      len1_r <= SB'(unsigned'(q1_r[0])) + SB'(unsigned'(q1_r[1])) + SB'(unsigned'(q1_r[2]));
      line_r <= SB'(unsigned'(ql_r[0])) + SB'(unsigned'(ql_r[1])) + SB'(unsigned'(ql_r[2]));
    end
  end

  // Stage 4: magnitudes of the cross components; degenerate test.
  logic                 v4_r, deg4_r;
  logic [2*HB-1:0]      cm_r [3];
  logic [SB-1:0]        len1_4_r, line_4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cm_r[i] <= (2*HB)'(unsigned'(c_r[i][CB-1] ? -c_r[i] : c_r[i]));
      end
      deg4_r   <= (line_r == '0) ||
                  (line_r < SB'((2*LIM_BITS)'(lim_r) * (2*LIM_BITS)'(lim_r)));
      len1_4_r <= len1_r;
      line_4_r <= line_r;
    end
  end

  // Stage 5: partial products of each magnitude split into two halves.
  logic                 v5_r, deg5_r;
  logic [2*HB-1:0]      hh_r [3], hl_r [3], ll_r [3];
  logic [SB-1:0]        len1_5_r, line_5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= cm_r[i][2*HB-1:HB] * cm_r[i][2*HB-1:HB];
        hl_r[i] <= cm_r[i][2*HB-1:HB] * cm_r[i][HB-1:0];
        ll_r[i] <= cm_r[i][HB-1:0] * cm_r[i][HB-1:0];
      end
      deg5_r   <= deg4_r;
      len1_5_r <= len1_4_r;
      line_5_r <= line_4_r;
    end
  end

  // Stage 6: squares of the cross components from the partial products.
  logic                 v6_r, deg6_r;
  logic [2*CB-1:0]      cs_r [3];
  logic [SB-1:0]        len1_6_r, line_6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cs_r[i] <= ((2*CB)'(hh_r[i]) << (2*HB)) + ((2*CB)'(hl_r[i]) << (HB+1))
                   + (2*CB)'(ll_r[i]);
      end
      deg6_r   <= deg5_r;
      len1_6_r <= len1_5_r;
      line_6_r <= line_5_r;
    end
  end

  // Stage 7: numerator; a degenerate item divides |d1|^2 by one.
  logic          v7_r, deg7_r;
  logic [NB-1:0] num7_r;
  logic [LB-1:0] den7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      deg7_r <= deg6_r;
      num7_r <= deg6_r ? NB'(len1_6_r)
                       : NB'(cs_r[0]) + NB'(cs_r[1]) + NB'(cs_r[2]);
      den7_r <= deg6_r ? LB'(1) : line_6_r;
    end
  end

  // Divider chain, one quotient bit per cell, MSB first.
  logic          dv [NB+1];
  logic [NB-1:0] dn [NB+1];
  logic [LB-1:0] dd [NB+1];
  logic [NB:0]   dr [NB+1];
  logic [NB-1:0] dq [NB+1];
  logic [LB:0]   da [NB+1];
  assign dv[0] = v7_r;
  assign dn[0] = num7_r;
  assign dd[0] = den7_r;
  assign dr[0] = '0;
  assign dq[0] = '0;
  assign da[0] = {deg7_r, LB'(0)};
  for (genvar g = 0; g < NB; g++) begin : g_div
    pld3_div_cell #(.NB(NB), .DB(LB), .QB(NB), .BIT(NB-1-g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(dv[g]), .num_in(dn[g]), .den_in(dd[g]), .rem_in(dr[g]),
      .q_in(dq[g]), .aux_in(da[g]),
      .vld_out(dv[g+1]), .num_out(dn[g+1]), .den_out(dd[g+1]), .rem_out(dr[g+1]),
      .q_out(dq[g+1]), .aux_out(da[g+1])
    );
  end

  // Square-root chain, one root bit per cell, MSB first.
  logic          sv [RB+1];
  logic [NB-1:0] sval [RB+1];
  logic [RB-1:0] sr [RB+1];
  logic [RB+1:0] srem [RB+1];
  logic          sf [RB+1];
  assign sv[0]   = dv[NB];
  assign sval[0] = dq[NB];
  assign sr[0]   = '0;
  assign srem[0] = '0;
  assign sf[0]   = da[NB][LB];
  for (genvar g = 0; g < RB; g++) begin : g_sqrt
    pld3_sqrt_cell #(.VB(NB), .RB(RB), .BIT(RB-1-g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(sv[g]), .v_in(sval[g]), .r_in(sr[g]), .rem_in(srem[g]),
      .flag_in(sf[g]),
      .vld_out(sv[g+1]), .v_out(sval[g+1]), .r_out(sr[g+1]), .rem_out(srem[g+1]),
      .flag_out(sf[g+1])
    );
  end

  // Saturate and hold for the consumer.
  logic [DIST_BITS-1:0] dist_sat;
  always_comb begin
    if (RB > DIST_BITS && (sr[RB] >> DIST_BITS) != '0) dist_sat = DIST_MAX;
    else dist_sat = DIST_BITS'(sr[RB]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= sv[RB];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      od_r   <= dist_sat;
      odeg_r <= sf[RB];
    end
  end

  assign out_valid      = ov_r;
  assign out_distance   = od_r;
  assign out_degenerate = odeg_r;
endmodule
`default_nettype wire

/* sim/point_line_distance_3d_unit_tb.sv */
// Self-checking testbench for point_line_distance_3d_unit: random and directed point sets,
// an exact integer distance predictor and a beat-by-beat output check. Depends on pld3_pkg.
`timescale 1ns / 100ps
module point_line_distance_3d_unit_tb;
  import pld3_pkg::*;

  localparam int CB         = 24;
  localparam int DRAIN_WAIT = 260;
  localparam int CYCLE_CAP  = 3000000;

  typedef struct packed {
    logic signed [CB-1:0] ax, ay, az, bx, by, bz, px, py, pz;
  } points_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] dist_val;
    logic                 degen;
  } dist_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_degenerate;
  logic cfg_valid, cfg_ready;
  logic [LIM_BITS-1:0] cfg_short_line_limit;
  logic [DIST_BITS-1:0] out_distance;
  points_t cur;

  points_t pending_points[$];
  dist_t   expected_dist[$];
  logic [LIM_BITS-1:0] line_limit;
  int  error_count = 0;
  int  cycle_count = 0;
  int  in_gap = 0, out_gap = 0;
  bit  in_took = 0;
  bit  quiet = 0;

  point_line_distance_3d_unit #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_x(cur.ax), .in_a_y(cur.ay), .in_a_z(cur.az),
    .in_b_x(cur.bx), .in_b_y(cur.by), .in_b_z(cur.bz),
    .in_p_x(cur.px), .in_p_y(cur.py), .in_p_z(cur.pz),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_distance(out_distance), .out_degenerate(out_degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_short_line_limit(cfg_short_line_limit)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Floored square root, saturated to the output width.
  function automatic logic [DIST_BITS-1:0] floor_root(logic [127:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return (r > {39'd0, DIST_MAX}) ? DIST_MAX : r[DIST_BITS-1:0];
  endfunction

  function automatic logic [127:0] square_of(logic signed [63:0] v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return {64'd0, m} * {64'd0, m};
  endfunction

  // Exact distance of P from the line through A and B.
  function automatic dist_t line_distance(points_t q, logic [LIM_BITS-1:0] lim);
    logic signed [63:0] a[3], b[3], p[3], d1[3], d2[3], cx, cy, cz;
    logic [127:0] len1, line_sq, cross_sq;
    dist_t r;
    a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
    b[0] = q.bx; b[1] = q.by; b[2] = q.bz;
    p[0] = q.px; p[1] = q.py; p[2] = q.pz;
    len1 = '0;
    line_sq = '0;
    for (int i = 0; i < 3; i++) begin
      d1[i] = p[i] - a[i];
      d2[i] = p[i] - b[i];
      len1 += square_of(d1[i]);
      line_sq += square_of(a[i] - b[i]);
    end
    if (line_sq == 0 || line_sq < {112'd0, 16'(lim) * 16'(lim)}) begin
      r.dist_val = floor_root(len1);
      r.degen = 1'b1;
    end else begin
      cx = d1[1] * d2[2] - d1[2] * d2[1];
      cy = d1[2] * d2[0] - d1[0] * d2[2];
      cz = d1[0] * d2[1] - d1[1] * d2[0];
      cross_sq = square_of(cx) + square_of(cy) + square_of(cz);
      r.dist_val = floor_root(cross_sq / line_sq);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [CB-1:0] near(logic signed [CB-1:0] c, int span);
    return c + CB'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random point set; most are short or ordinary lines with random content.
  function automatic points_t random_points();
    points_t q;
    int kind;
    logic signed [CB-1:0] dx, dy, dz;
    q = points_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom()});
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        // Short line near the configured limit.
        q.bx = near(q.ax, 300); q.by = near(q.ay, 300); q.bz = near(q.az, 300);
      end
      2: begin
        q.bx = near(q.ax, 2); q.by = near(q.ay, 2); q.bz = near(q.az, 2);
        if ($urandom_range(0, 1)) q.bx = q.ax;
      end
      3: begin
        // Test point on the line through A and B.
        dx = q.bx - q.ax; dy = q.by - q.ay; dz = q.bz - q.az;
        dx = dx >>> 2; dy = dy >>> 2; dz = dz >>> 2;
        q.bx = q.ax + dx; q.by = q.ay + dy; q.bz = q.az + dz;
        q.px = q.bx + dx; q.py = q.by + dy; q.pz = q.bz + dz;
      end
      4, 5: begin
        q.ax = near(0, 4000); q.ay = near(0, 4000); q.az = near(0, 4000);
        q.bx = near(0, 4000); q.by = near(0, 4000); q.bz = near(0, 4000);
        q.px = near(0, 4000); q.py = near(0, 4000); q.pz = near(0, 4000);
      end
      default: ;
    endcase
    return q;
  endfunction

  // Input driver: a new beat once the last one was taken and any gap has run out.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        cur <= pending_points.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap <= pick_gap();
    end
  end

  // Monitor: predict on each accepted input beat, check each result beat.
  always @(posedge clk) begin
    dist_t want;
    cycle_count <= cycle_count + 1;
    in_took = rst_n && in_valid && in_ready;
    if (in_took) expected_dist.push_back(line_distance(cur, line_limit));
    if (rst_n && out_valid && out_ready) begin
      if (expected_dist.size() == 0) begin
        $error("result beat with nothing expected: distance %0d", out_distance);
        error_count++;
      end else begin
        want = expected_dist.pop_front();
        if (out_distance !== want.dist_val) begin
          $error("distance expected %0d actual %0d", want.dist_val, out_distance);
          error_count++;
        end
        if (out_degenerate !== want.degen) begin
          $error("degenerate expected %0d actual %0d", want.degen, out_degenerate);
          error_count++;
        end
      end
    end
    if (cycle_count > CYCLE_CAP) begin
      $display("[point_line_distance_3d_unit] ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_dist.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIM_BITS-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_short_line_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    line_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_point_set(logic signed [CB-1:0] ax, ay, az, bx, by, bz, px, py, pz);
    pending_points.push_back('{ax, ay, az, bx, by, bz, px, py, pz});
  endtask

  // Directed edge cases, then random phases over several limit settings.
  initial begin
    localparam logic signed [CB-1:0] MX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] MN = {1'b1, {(CB-1){1'b0}}};
    logic [LIM_BITS-1:0] limits[5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_short_line_limit = 8'd1;
    cur = '0;
    line_limit = 8'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit: zero-length line, unit line, extremes of the fields.
    add_point_set(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_point_set(5, 5, 5, 5, 5, 5, MX, MN, MX);
    add_point_set(0, 0, 0, 1, 0, 0, 0, 7, 0);
    add_point_set(MN, MN, MN, MX, MX, MX, MX, MN, MN);
    add_point_set(MN, MN, MN, MX, MX, MX, 0, 0, 0);
    add_point_set(MX, MX, MX, MN, MN, MN, MN, MX, MN);
    add_point_set(MN, MN, MN, MN, MN, MN, MX, MX, MX);
    add_point_set(MN, 0, 0, MX, 0, 0, 0, MX, MN);
    add_point_set(-1, -1, -1, 1, 1, 1, 3, 3, 3);
    add_point_set(0, 0, 0, 0, 0, 1, MX, MX, 0);
    drain();

    // Limit zero: zero-length line still degenerate, one-LSB line is not.
    write_limit(8'd0);
    add_point_set(MX, MN, 7, MX, MN, 7, MN, MX, -7);
    add_point_set(0, 0, 0, 0, 1, 0, 100, 0, MX);
    add_point_set(MN, MN, MN, MN, MN, MN + 1, MX, MX, MX);
    drain();

    // Largest limit: lines just below and at 255 LSBs.
    write_limit(8'd255);
    add_point_set(0, 0, 0, 254, 0, 0, 9, 900, -9);
    add_point_set(0, 0, 0, 255, 0, 0, 9, 900, -9);
    add_point_set(10, 10, 10, 157, 157, 157, MN, MX, 0);
    add_point_set(10, 10, 10, 157, 157, 158, MN, MX, 0);
    add_point_set(MX, MX, MX, MX - 100, MX - 100, MX - 100, MN, MN, MN);
    drain();

    limits = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(2, 254)), 8'($urandom_range(2, 254))};
    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 2);
      write_limit(limits[ph]);
      for (int n = 0; n < 380; n++) begin
        pending_points.push_back(random_points());
        // Once per phase the sender holds until all results are back.
        if (n == 190) drain();
      end
      drain();
    end

    if (error_count == 0) begin
      $display("[point_line_distance_3d_unit] OK");
    end else begin
      $display("[point_line_distance_3d_unit] ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/pld3_pkg.sv
hw/rtl/pld3_div_cell.sv
hw/rtl/pld3_sqrt_cell.sv
hw/rtl/point_line_distance_3d_unit.sv
sim/point_line_distance_3d_unit_tb.sv
